[rtl/square_sine_tone_generator_assert.svh]
// Assertion macros for the tone generator.
`ifndef SQUARE_SINE_TONE_GENERATOR_ASSERT_SVH
`define SQUARE_SINE_TONE_GENERATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SSTG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tone generator: same-cycle check failed");
// Next-cycle implication.
`define SSTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tone generator: next-cycle check failed");
`else
`define SSTG_ASSERT_NOW(label, clk, rst, ante, cons)
`define SSTG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/sstg_pkg.sv]
`default_nettype none
package sstg_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int VOLUME_W    = 15;
   localparam int PERIOD_W    = 16;
   localparam int STEP_W      = 32;
   localparam int COUNT_W     = 24;
   localparam int MAG_W       = 15;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_WAVE_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TOGGLE_PERIOD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_VOLUME        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_COUNT  = 3'd4;

   localparam logic MODE_SQUARE = 1'b0;
   localparam logic MODE_SINE   = 1'b1;

   localparam logic [PERIOD_W-1:0] RST_TOGGLE_PERIOD = 16'd441;
   localparam logic [STEP_W-1:0]   RST_PHASE_STEP    = 32'd4870534;
   localparam logic [VOLUME_W-1:0] RST_VOLUME        = 15'd3000;
   localparam logic [COUNT_W-1:0]  RST_SAMPLE_COUNT  = 24'd176400;

   // pi/2 in Q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q15_MAX     = 64'd32767;

   typedef struct packed {
      logic                wave_mode;
      logic [PERIOD_W-1:0] toggle_period;
      logic [STEP_W-1:0]   phase_step;
      logic [VOLUME_W-1:0] volume;
      logic [COUNT_W-1:0]  sample_count;
   } cfg_type;

   // Per-sample fields carried from the state stage to the output stage
   typedef struct packed {
      logic                wave_mode;
      logic [SAMPLE_W-1:0] square_sample;
      logic                active;
      logic                negate;
   } beat_type;

   function automatic logic [63:0] taylor_step(input logic [63:0] term, input logic [63:0] x);
      logic [63:0] t;
      t = (term * x) >> 30;
      t = (t * x) >> 30;
      return t;
   endfunction

   // Quarter-wave entry i of a table with 2^table_bits steps, Q0.15
   function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i,
                                                   input int unsigned table_bits);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x    = (64'(i) * HALF_PI_Q30) >> table_bits;
      term = x;
      sum  = x;
      term = taylor_step(term, x) / 64'd6;   sum = sum - term;
      term = taylor_step(term, x) / 64'd20;  sum = sum + term;
      term = taylor_step(term, x) / 64'd42;  sum = sum - term;
      term = taylor_step(term, x) / 64'd72;  sum = sum + term;
      term = taylor_step(term, x) / 64'd110; sum = sum - term;
      term = taylor_step(term, x) / 64'd156; sum = sum + term;
      term = taylor_step(term, x) / 64'd210; sum = sum - term;
      v = ((sum * 64'd32768) + (64'd1 << 29)) >> 30;
      if (v > Q15_MAX) begin
         v = Q15_MAX;
      end
      return v[MAG_W-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/sstg_if.sv]
`default_nettype none
interface sstg_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface sstg_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sstg_pkg::SAMPLE_W-1:0]  sample;
   logic                                  active;
   modport source (output valid, output sample, output active, input ready);
   modport sink (input valid, input sample, input active, output ready);
endinterface
`default_nettype wire

[rtl/sstg_state.sv]
`default_nettype none
module sstg_state #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          accept,
   input  wire                          restart,
   input  wire sstg_pkg::cfg_type       cfg,
   output sstg_pkg::beat_type           beat,
   output logic [SINE_TABLE_BITS:0]     rom_addr
);
   localparam int ADDR_W = SINE_TABLE_BITS + 1;
   localparam logic [ADDR_W-1:0] TBL_N = ADDR_W'(1) << SINE_TABLE_BITS;

   logic [PHASE_BITS-1:0]         phase_ff, phase_in, phase_start;
   logic [sstg_pkg::PERIOD_W-1:0] toggle_count_ff, toggle_count_in, tc_start, tc_base;
   logic                          level_high_ff, level_high_in, level_now, wrap;
   logic [sstg_pkg::COUNT_W-1:0]  remaining_ff, remaining_in, rem_start;
   logic [SINE_TABLE_BITS-1:0]    idx;
   logic                          active;

   always_comb begin
      phase_start = restart ? '0 : phase_ff;
      tc_start    = restart ? '0 : toggle_count_ff;
      rem_start   = restart ? cfg.sample_count : remaining_ff;

      // square: flip the level once the count reaches the period
      wrap      = (tc_start >= cfg.toggle_period);
      level_now = wrap ? !level_high_ff : level_high_ff;
      tc_base   = wrap ? '0 : tc_start;

      // sine: fold the quadrant onto the quarter table
      idx      = phase_start[PHASE_BITS-3 -: SINE_TABLE_BITS];
      rom_addr = phase_start[PHASE_BITS-2] ? (TBL_N - {1'b0, idx}) : {1'b0, idx};

      active = (rem_start != '0);

      beat.wave_mode     = cfg.wave_mode;
      beat.square_sample = level_now ? {1'b0, cfg.volume}
                                     : (sstg_pkg::SAMPLE_W'(0) - {1'b0, cfg.volume});
      beat.active        = active;
      beat.negate        = phase_start[PHASE_BITS-1];

      remaining_in = active ? (rem_start - 1'b1) : rem_start;
      if (cfg.wave_mode == sstg_pkg::MODE_SQUARE) begin
         toggle_count_in = tc_base + 1'b1;
         level_high_in   = level_now;
         phase_in        = phase_start;
      end else begin
         toggle_count_in = tc_start;
         level_high_in   = level_high_ff;
         phase_in        = phase_start + PHASE_BITS'(cfg.phase_step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= '0;
         toggle_count_ff <= '0;
         level_high_ff   <= 1'b0;
         remaining_ff    <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         toggle_count_ff <= toggle_count_in;
         level_high_ff   <= level_high_in;
         remaining_ff    <= remaining_in;
      end
   end
endmodule
`default_nettype wire

[rtl/sstg_sine_rom.sv]
`default_nettype none
module sstg_sine_rom #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  wire                           clock,
   input  wire                           rd_en,
   input  wire  [SINE_TABLE_BITS:0]      rd_addr,
   output logic [sstg_pkg::MAG_W-1:0]    rd_data
);
   localparam int DEPTH = (1 << SINE_TABLE_BITS) + 1;

   typedef logic [sstg_pkg::MAG_W-1:0] rom_type [DEPTH];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i < DEPTH; i++) begin
         r[i] = sstg_pkg::sine_entry(i, SINE_TABLE_BITS);
      end
      return r;
   endfunction

   localparam rom_type ROM = build_rom();

   logic [sstg_pkg::MAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[rtl/sstg_scale.sv]
`default_nettype none
module sstg_scale (
   input  wire  [sstg_pkg::VOLUME_W-1:0] volume,
   input  wire  [sstg_pkg::MAG_W-1:0]    mag,
   input  wire sstg_pkg::beat_type       beat,
   output logic [sstg_pkg::SAMPLE_W-1:0] sample
);
   logic [sstg_pkg::VOLUME_W+sstg_pkg::MAG_W-1:0] prod;
   logic [sstg_pkg::SAMPLE_W-1:0]                 mag_scaled, sine_val;

   always_comb begin
      prod       = volume * mag;
      // drop the Q15 fraction: truncate the magnitude, then apply the sign
      mag_scaled = {1'b0, prod[sstg_pkg::VOLUME_W+sstg_pkg::MAG_W-1 -: sstg_pkg::MAG_W]};
      sine_val   = beat.negate ? (sstg_pkg::SAMPLE_W'(0) - mag_scaled) : mag_scaled;
      sample     = (beat.wave_mode == sstg_pkg::MODE_SINE) ? sine_val : beat.square_sample;
   end
endmodule
`default_nettype wire

[rtl/square_sine_tone_generator.sv]
// Square and sine tone generator.
// Each req beat is one tick: its restart bit, when set, clears the phase and
// the toggle counter and reloads the sample countdown before that sample.
// Each req beat yields exactly one rsp beat carrying a signed 16-bit sample
// and an active flag (high while the countdown was above zero).
// Registers are written through the csr_ port (index 0 wave mode, 1 toggle
// period, 2 phase step, 3 volume, 4 sample count); write only while idle.
// Pipeline: 2 register stages; a req beat taken at an edge has its state
// update and table read loaded at that edge into the middle stage, and its
// scaled sample is loaded into the output register once that register is
// free, after which the rsp beat is offered.
// Throughput: one beat per cycle while rsp.ready is high; the combinational
// phase add and toggle compare set that figure.
// Stall: when rsp.ready is low the output register holds its beat and the
// middle stage holds one more; req.ready drops only when both are full.
// Reset (synchronous, active high) restores register defaults, clears phase,
// counter, level and countdown, and empties the pipeline.
`default_nettype none
`include "square_sine_tone_generator_assert.svh"
module square_sine_tone_generator #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   sstg_req_if.sink                             req,
   sstg_rsp_if.source                           rsp,
   input  wire                                  csr_wr_en,
   input  wire  [sstg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [sstg_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   // configuration registers
   logic                           wave_mode_ff;
   logic [sstg_pkg::PERIOD_W-1:0]  toggle_period_ff;
   logic [sstg_pkg::STEP_W-1:0]    phase_step_ff;
   logic [sstg_pkg::VOLUME_W-1:0]  volume_ff;
   logic [sstg_pkg::COUNT_W-1:0]   sample_count_ff;
   sstg_pkg::cfg_type              cfg;

   // pipeline
   logic                           req_accept, out_free;
   logic                           s1_valid_ff, s1_valid_in;
   sstg_pkg::beat_type             s1_ff, beat;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sstg_pkg::SAMPLE_W-1:0]  rsp_sample_ff, sample_in;
   logic                           rsp_active_ff;
   logic [SINE_TABLE_BITS:0]       rom_addr;
   logic [sstg_pkg::MAG_W-1:0]     mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff     <= sstg_pkg::MODE_SQUARE;
         toggle_period_ff <= sstg_pkg::RST_TOGGLE_PERIOD;
         phase_step_ff    <= sstg_pkg::RST_PHASE_STEP;
         volume_ff        <= sstg_pkg::RST_VOLUME;
         sample_count_ff  <= sstg_pkg::RST_SAMPLE_COUNT;
      end else if (csr_wr_en) begin
         case (csr_index)
            sstg_pkg::REG_WAVE_MODE: begin
               wave_mode_ff <= csr_wdata[0];
            end
            sstg_pkg::REG_TOGGLE_PERIOD: begin
               toggle_period_ff <= csr_wdata[sstg_pkg::PERIOD_W-1:0];
            end
            sstg_pkg::REG_PHASE_STEP: begin
               phase_step_ff <= csr_wdata[sstg_pkg::STEP_W-1:0];
            end
            sstg_pkg::REG_VOLUME: begin
               volume_ff <= csr_wdata[sstg_pkg::VOLUME_W-1:0];
            end
            sstg_pkg::REG_SAMPLE_COUNT: begin
               sample_count_ff <= csr_wdata[sstg_pkg::COUNT_W-1:0];
            end
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   always_comb begin
      cfg.wave_mode     = wave_mode_ff;
      cfg.toggle_period = toggle_period_ff;
      cfg.phase_step    = phase_step_ff;
      cfg.volume        = volume_ff;
      cfg.sample_count  = sample_count_ff;
   end

   // Handshake: the output register frees when empty or taken this cycle;
   // the middle stage frees when empty or moving on.
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready  = !s1_valid_ff || out_free;
   assign req_accept = req.valid && req.ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !out_free);
   assign rsp_valid_in = out_free ? s1_valid_ff : 1'b1;

   sstg_state #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .restart  (req.restart),
      .cfg      (cfg),
      .beat     (beat),
      .rom_addr (rom_addr)
   );

   // Table read lands alongside the middle-stage beat
   sstg_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (rom_addr),
      .rd_data (mag)
   );

   sstg_scale u_scale (
      .volume (volume_ff),
      .mag    (mag),
      .beat   (s1_ff),
      .sample (sample_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load on acceptance, advance into the output when it frees
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= beat;
      end
      if (out_free && s1_valid_ff) begin
         rsp_sample_ff <= sample_in;
         rsp_active_ff <= s1_ff.active;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.sample = rsp_sample_ff;
   assign rsp.active = rsp_active_ff;

   // a full middle stage behind a stalled output must hold its beat
   `SSTG_ASSERT_NEXT(a_mid_hold, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp.ready, s1_valid_ff)
   // a restart with a non-zero count must mark its own sample active
   `SSTG_ASSERT_NEXT(a_restart_active, clock, reset, req_accept && req.restart && (sample_count_ff != '0), s1_ff.active)
   // keep the input open whenever the output register can move on
   `SSTG_ASSERT_NOW(a_in_ready, clock, reset, out_free, req.ready)
   // a stalled rsp beat holds its valid and its sample
   `SSTG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp.ready, rsp_valid_ff && $stable(rsp_sample_ff))

endmodule
`default_nettype wire
